@@ src/ttuv_pkg.sv @@
// Package for the triangle tangent block: shared constants and the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package ttuv_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int TANGENT_WIDTH_DEF = 16;
  localparam int IN_WIDTH          = 32;

  // Largest scaled magnitude has exactly this many bits before the root.
  localparam int NORM_BITS  = 31;
  localparam int SUM_WIDTH  = 2 * NORM_BITS + 2;
  localparam int ROOT_STEPS = SUM_WIDTH / 2;

  // Component selectors for the shared square and divide steps.
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic       load_c1;
    logic       load_c2;
    logic       start;
    logic       mul_step;
    logic       mul_sub;
    logic       mul_last;
    logic       swap;
    logic       check;
    logic       norm_step;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] idx;
    logic       out_load;
  } ttuv_cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_ok;
  } ttuv_status_t;

endpackage

@@ src/ttuv_datapath.sv @@
// Datapath of the triangle tangent block: corner store, shift-add products,
// normalize shifter, root and divide units, result registers. Uses ttuv_pkg.
`timescale 1ns / 1ps

module ttuv_datapath #(
  parameter int CW = ttuv_pkg::COORD_WIDTH_DEF,
  parameter int TW = ttuv_pkg::TANGENT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  ttuv_pkg::ttuv_cmd_t          cmd_i,
  output ttuv_pkg::ttuv_status_t       status_o,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] pos_x_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] pos_y_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] pos_z_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] tex_u_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] tex_v_i,
  output logic signed [TW-1:0]         tangent_x_o,
  output logic signed [TW-1:0]         tangent_y_o,
  output logic signed [TW-1:0]         tangent_z_o,
  output logic                         degenerate_o
);

  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW + 1;
  localparam int NB   = ttuv_pkg::NORM_BITS;
  localparam int SQW  = ttuv_pkg::SUM_WIDTH;
  localparam int RTW  = SQW / 2;
  localparam int F    = TW - 2;
  localparam int NUMW = NB + F + 1;

  function automatic logic [DW-1:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
    dif = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [PW-1:0] sx(input logic [DW-1:0] a);
    sx = {{(PW-DW){a[DW-1]}}, a};
  endfunction

  logic [CW-1:0] hp_q [6];
  logic [CW-1:0] ht_q [4];
  logic [PW-1:0] ma_q [4];
  logic [DW-1:0] mb_q [4];
  logic [PW-1:0] acc_q [4];
  logic [DW-1:0] mr_q, dv1_q;
  logic [PW-1:0] mag_q [3];
  logic [2:0]    sneg_q;
  logic          dneg_q, degen_q;
  logic [2*NB-1:0] sqr_q;
  logic [SQW-1:0]  sum_q, sx_q, rt_q, bt_q;
  logic [RTW-1:0]  rem_q;
  logic [F:0]      lo_q, quo_q;
  logic [TW-1:0]   res_q [3];
  logic [TW-1:0]   tan_q [3];
  logic            dg_q;

  logic [CW-1:0] px, py, pz, tu, tv;
  logic [DW-1:0] e1 [3];
  logic [DW-1:0] e2 [3];
  logic [DW-1:0] du1, dv1, du2, dv2;
  logic [PW-1:0] orv;
  logic [NB-1:0] sm_sel;
  logic          sn_sel;
  logic [SQW-1:0] sum_d, rt_t;
  logic [NUMW-1:0] num;
  logic [RTW:0]    dt;
  logic [TW-1:0]   qv;

  assign px = pos_x_i[CW-1:0];
  assign py = pos_y_i[CW-1:0];
  assign pz = pos_z_i[CW-1:0];
  assign tu = tex_u_i[CW-1:0];
  assign tv = tex_v_i[CW-1:0];

  assign e1[0] = dif(hp_q[3], hp_q[0]);
  assign e1[1] = dif(hp_q[4], hp_q[1]);
  assign e1[2] = dif(hp_q[5], hp_q[2]);
  assign e2[0] = dif(px, hp_q[0]);
  assign e2[1] = dif(py, hp_q[1]);
  assign e2[2] = dif(pz, hp_q[2]);
  assign du1   = dif(ht_q[2], ht_q[0]);
  assign dv1   = dif(ht_q[3], ht_q[1]);
  assign du2   = dif(tu, ht_q[0]);
  assign dv2   = dif(tv, ht_q[1]);

  assign orv = mag_q[0] | mag_q[1] | mag_q[2];
  assign status_o.norm_ok = orv[NB-1] && !(|orv[PW-1:NB]);
  assign status_o.degen   = (acc_q[0] == '0) ||
                            ((acc_q[1] == '0) && (acc_q[2] == '0) && (acc_q[3] == '0));

  always_comb begin
    case (cmd_i.idx)
      ttuv_pkg::COMP_X: begin sm_sel = mag_q[0][NB-1:0]; sn_sel = sneg_q[0]; end
      ttuv_pkg::COMP_Y: begin sm_sel = mag_q[1][NB-1:0]; sn_sel = sneg_q[1]; end
      default:          begin sm_sel = mag_q[2][NB-1:0]; sn_sel = sneg_q[2]; end
    endcase
  end

  assign sum_d = sum_q + {{(SQW-2*NB){1'b0}}, sqr_q};
  assign rt_t  = rt_q + bt_q;
  assign num   = {1'b0, sm_sel, {F{1'b0}}} + {{(NUMW-RTW+1){1'b0}}, rt_q[RTW-1:1]};
  assign dt    = {rem_q, lo_q[F]};
  assign qv    = {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_c1) begin
      hp_q[0] <= px; hp_q[1] <= py; hp_q[2] <= pz;
      ht_q[0] <= tu; ht_q[1] <= tv;
    end
    if (cmd_i.load_c2) begin
      hp_q[3] <= px; hp_q[4] <= py; hp_q[5] <= pz;
      ht_q[2] <= tu; ht_q[3] <= tv;
    end

    // Shift-add products: dv2 times first edges, then minus dv1 times second.
    if (cmd_i.start) begin
      ma_q[0] <= sx(du1);
      mb_q[0] <= du2;
      for (int j = 0; j < 3; j++) begin
        ma_q[j+1] <= sx(e1[j]);
        mb_q[j+1] <= e2[j];
      end
      for (int j = 0; j < 4; j++) acc_q[j] <= '0;
      mr_q  <= dv2;
      dv1_q <= dv1;
    end else if (cmd_i.mul_step) begin
      for (int j = 0; j < 4; j++) begin
        if (mr_q[0]) begin
          if (cmd_i.mul_sub ^ cmd_i.mul_last) acc_q[j] <= acc_q[j] - ma_q[j];
          else                                acc_q[j] <= acc_q[j] + ma_q[j];
        end
        ma_q[j] <= ma_q[j] << 1;
      end
      mr_q <= mr_q >> 1;
    end else if (cmd_i.swap) begin
      for (int j = 0; j < 4; j++) ma_q[j] <= sx(mb_q[j]);
      mr_q <= dv1_q;
    end

    if (cmd_i.check) begin
      degen_q <= status_o.degen;
      dneg_q  <= acc_q[0][PW-1];
      sum_q   <= '0;
      for (int j = 0; j < 3; j++) begin
        sneg_q[j] <= acc_q[j+1][PW-1];
        mag_q[j]  <= acc_q[j+1][PW-1] ? (~acc_q[j+1] + 1'b1) : acc_q[j+1];
      end
    end else if (cmd_i.norm_step) begin
      for (int j = 0; j < 3; j++) begin
        if (|orv[PW-1:NB]) mag_q[j] <= mag_q[j] >> 1;
        else               mag_q[j] <= mag_q[j] << 1;
      end
    end

    if (cmd_i.sq_mul) sqr_q <= {{NB{1'b0}}, sm_sel} * {{NB{1'b0}}, sm_sel};
    if (cmd_i.sq_acc) sum_q <= sum_d;

    if (cmd_i.sqrt_init) begin
      sx_q <= sum_d;
      rt_q <= '0;
      bt_q <= SQW'(1) << (SQW - 2);
    end else if (cmd_i.sqrt_step) begin
      if (sx_q >= rt_t) begin
        sx_q <= sx_q - rt_t;
        rt_q <= (rt_q >> 1) + bt_q;
      end else begin
        rt_q <= rt_q >> 1;
      end
      bt_q <= bt_q >> 2;
    end

    if (cmd_i.div_init) begin
      rem_q <= {{(RTW-NB){1'b0}}, num[NUMW-1:F+1]};
      lo_q  <= num[F:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dt >= {1'b0, rt_q[RTW-1:0]}) begin
        rem_q <= RTW'(dt - {1'b0, rt_q[RTW-1:0]});
        quo_q <= {quo_q[F-1:0], 1'b1};
      end else begin
        rem_q <= dt[RTW-1:0];
        quo_q <= {quo_q[F-1:0], 1'b0};
      end
      lo_q <= lo_q << 1;
    end

    if (cmd_i.div_store) begin
      case (cmd_i.idx)
        ttuv_pkg::COMP_X: res_q[0] <= (sn_sel ^ dneg_q) ? (TW'(0) - qv) : qv;
        ttuv_pkg::COMP_Y: res_q[1] <= (sn_sel ^ dneg_q) ? (TW'(0) - qv) : qv;
        default:          res_q[2] <= (sn_sel ^ dneg_q) ? (TW'(0) - qv) : qv;
      endcase
    end

    if (cmd_i.out_load) begin
      for (int j = 0; j < 3; j++) tan_q[j] <= degen_q ? '0 : res_q[j];
      dg_q <= degen_q;
    end
  end

  assign tangent_x_o  = tan_q[0];
  assign tangent_y_o  = tan_q[1];
  assign tangent_z_o  = tan_q[2];
  assign degenerate_o = dg_q;

endmodule

@@ src/ttuv_ctrl.sv @@
// Controller of the triangle tangent block: corner counting, sequencing of
// the datapath steps and the output valid flag. Uses ttuv_pkg.
`timescale 1ns / 1ps

module ttuv_ctrl #(
  parameter int CW = ttuv_pkg::COORD_WIDTH_DEF,
  parameter int TW = ttuv_pkg::TANGENT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ttuv_pkg::ttuv_status_t status_i,
  output ttuv_pkg::ttuv_cmd_t    cmd_o
);

  localparam int DW   = CW + 1;
  localparam int F    = TW - 2;
  localparam int RS   = ttuv_pkg::ROOT_STEPS;
  localparam int MAXC = (DW > RS) ? DW : RS;
  localparam int CNTW = $clog2(MAXC + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_A, S_SWAP, S_MUL_B, S_CHECK, S_NORM, S_SQ,
    S_SQRT, S_DIV_INIT, S_DIV, S_DIV_STORE, S_DONE
  } state_e;

  state_e          state_q;
  logic [1:0]      corner_q;
  logic [CNTW-1:0] cnt_q;
  logic [1:0]      cidx_q;
  logic            out_valid_q;
  logic            in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.idx = (state_q == S_SQ) ? cnt_q[1:0] : cidx_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_c1 = in_acc && (corner_q == 2'd0);
        cmd_o.load_c2 = in_acc && (corner_q == 2'd1);
        cmd_o.start   = in_acc && (corner_q == 2'd2);
      end
      S_MUL_A: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_last = (cnt_q == CNTW'(DW - 1));
      end
      S_SWAP: cmd_o.swap = 1'b1;
      S_MUL_B: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sub  = 1'b1;
        cmd_o.mul_last = (cnt_q == CNTW'(DW - 1));
      end
      S_CHECK: cmd_o.check = 1'b1;
      S_NORM:  cmd_o.norm_step = !status_i.norm_ok;
      S_SQ: begin
        cmd_o.sq_mul    = (cnt_q != CNTW'(3));
        cmd_o.sq_acc    = (cnt_q != '0);
        cmd_o.sqrt_init = (cnt_q == CNTW'(3));
      end
      S_SQRT:      cmd_o.sqrt_step = 1'b1;
      S_DIV_INIT:  cmd_o.div_init  = 1'b1;
      S_DIV:       cmd_o.div_step  = 1'b1;
      S_DIV_STORE: cmd_o.div_store = 1'b1;
      S_DONE:      cmd_o.out_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      corner_q    <= 2'd0;
      cnt_q       <= '0;
      cidx_q      <= ttuv_pkg::COMP_X;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load)  out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (corner_q == 2'd2) begin
              corner_q <= 2'd0;
              cnt_q    <= '0;
              state_q  <= S_MUL_A;
            end else begin
              corner_q <= corner_q + 2'd1;
            end
          end
        end
        S_MUL_A: begin
          if (cmd_o.mul_last) begin
            cnt_q   <= '0;
            state_q <= S_SWAP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SWAP: state_q <= S_MUL_B;
        S_MUL_B: begin
          if (cmd_o.mul_last) begin
            cnt_q   <= '0;
            state_q <= S_CHECK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CHECK: state_q <= status_i.degen ? S_DONE : S_NORM;
        S_NORM: begin
          if (status_i.norm_ok) begin
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_q == CNTW'(3)) begin
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQRT: begin
          if (cnt_q == CNTW'(RS - 1)) begin
            cidx_q  <= ttuv_pkg::COMP_X;
            state_q <= S_DIV_INIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CNTW'(F)) state_q <= S_DIV_STORE;
          else                   cnt_q <= cnt_q + 1'b1;
        end
        S_DIV_STORE: begin
          if (cidx_q == ttuv_pkg::COMP_Z) begin
            state_q <= S_DONE;
          end else begin
            cidx_q  <= cidx_q + 2'd1;
            state_q <= S_DIV_INIT;
          end
        end
        S_DONE: if (cmd_o.out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_corner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_q != 2'd3) else $error("corner count out of range");
  a_third_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (corner_q == 2'd2) |=> (state_q == S_MUL_A) && (corner_q == 2'd0))
    else $error("third corner did not start the product phase");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q) else $error("loaded result not marked valid");
  a_mul_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_A) || (state_q == S_MUL_B) |-> cnt_q < CNTW'(DW))
    else $error("product step count overrun");
`endif

endmodule

@@ src/triangle_tangent_from_uv.sv @@
// Top level of the triangle tangent block: joins the controller and the
// datapath. Depends on ttuv_pkg, ttuv_ctrl and ttuv_datapath.
`timescale 1ns / 1ps

// Corners stream in one transaction at a time; the first two of each
// triangle are stored as they are taken, and the third starts the tangent
// computation, during which no corner is taken. A triangle occupies the
// block for the shift-add products (one multiplier bit per cycle over four
// accumulators), the degeneracy check, the normalize shifts (one bit per
// cycle) until the magnitudes are in range, the squares, the bit-pair square
// root and the restoring division of each component, then the load of the
// result register, which waits while an earlier result is still pending.
// Degenerate triangles skip from the check straight to the result.
// A finished result waits in its own register, so the next triangle's
// corners are accepted while it is still pending.

module triangle_tangent_from_uv #(
  parameter int COORD_WIDTH   = ttuv_pkg::COORD_WIDTH_DEF,
  parameter int TANGENT_WIDTH = ttuv_pkg::TANGENT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] pos_x_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] pos_y_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] pos_z_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] tex_u_i,
  input  logic [ttuv_pkg::IN_WIDTH-1:0] tex_v_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [TANGENT_WIDTH-1:0] tangent_x_o,
  output logic signed [TANGENT_WIDTH-1:0] tangent_y_o,
  output logic signed [TANGENT_WIDTH-1:0] tangent_z_o,
  output logic                          degenerate_o
);

  // Command and status bundles between the sequencer and the datapath.
  ttuv_pkg::ttuv_cmd_t    cmd;
  ttuv_pkg::ttuv_status_t status;

  // Sequencer: counts corners, steps the shared units, owns output valid.
  ttuv_ctrl #(
    .CW (COORD_WIDTH),
    .TW (TANGENT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: holds corners, forms the direction, normalizes and divides.
  ttuv_datapath #(
    .CW (COORD_WIDTH),
    .TW (TANGENT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .tex_u_i      (tex_u_i),
    .tex_v_i      (tex_v_i),
    .tangent_x_o  (tangent_x_o),
    .tangent_y_o  (tangent_y_o),
    .tangent_z_o  (tangent_z_o),
    .degenerate_o (degenerate_o)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for triangle_tangent_from_uv: streams corners, predicts
// each tangent bit for bit and compares it with the block's result stream.
// Depends on ttuv_pkg and the triangle_tangent_from_uv RTL.
`timescale 1ns / 1ps

module tb;

  localparam int TW   = ttuv_pkg::TANGENT_WIDTH_DEF;
  localparam int FRAC = TW - 2;
  localparam int NB   = ttuv_pkg::NORM_BITS;

  typedef struct {
    logic [31:0] x, y, z, u, v;
  } corner_t;

  typedef struct {
    logic [TW-1:0] tx, ty, tz;
    logic          degen;
  } tangent_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, tex_u_i = '0, tex_v_i = '0;
  logic in_ready_o, out_valid_o, degenerate_o;
  logic signed [TW-1:0] tangent_x_o, tangent_y_o, tangent_z_o;

  triangle_tangent_from_uv u_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  corner_t  corner_q[$];
  tangent_t tangent_q[$];
  bit       fill_done = 1'b0;
  bit       failed = 1'b0;
  int       corners_held = 0;
  logic [31:0] held_pos[6];
  logic [31:0] held_tex[4];

  function automatic logic signed [127:0] sx(logic [31:0] raw);
    return {{96{raw[31]}}, raw};
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] val);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > val) b = b >> 2;
    while (b != 0) begin
      if (val >= r + b) begin
        val = val - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Hold the first two corners; on the third, compute the expected tangent.
  task automatic take_corner(corner_t c);
    logic signed [127:0] du1, dv1, du2, dv2, det, e1, e2;
    logic signed [127:0] dir[3];
    logic [127:0] mag[3];
    logic [63:0] sm[3], sum, norm, q;
    logic [TW-1:0] res[3];
    logic [31:0] p3[3];
    int bl;
    tangent_t t;
    if (corners_held < 2) begin
      held_pos[corners_held*3+0] = c.x;
      held_pos[corners_held*3+1] = c.y;
      held_pos[corners_held*3+2] = c.z;
      held_tex[corners_held*2+0] = c.u;
      held_tex[corners_held*2+1] = c.v;
      corners_held++;
      return;
    end
    corners_held = 0;
    p3[0] = c.x; p3[1] = c.y; p3[2] = c.z;
    du1 = sx(held_tex[2]) - sx(held_tex[0]);
    dv1 = sx(held_tex[3]) - sx(held_tex[1]);
    du2 = sx(c.u) - sx(held_tex[0]);
    dv2 = sx(c.v) - sx(held_tex[1]);
    det = du1 * dv2 - du2 * dv1;
    for (int i = 0; i < 3; i++) begin
      e1 = sx(held_pos[3+i]) - sx(held_pos[i]);
      e2 = sx(p3[i]) - sx(held_pos[i]);
      dir[i] = dv2 * e1 - dv1 * e2;
    end
    t = '{tx: '0, ty: '0, tz: '0, degen: 1'b1};
    if (det != 0 && (dir[0] != 0 || dir[1] != 0 || dir[2] != 0)) begin
      // Scale so the largest magnitude has exactly NB bits, then normalize.
      bl = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = dir[i][127] ? -dir[i] : dir[i];
        for (int b = 0; b < 128; b++) if (mag[i][b] && b + 1 > bl) bl = b + 1;
      end
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        sm[i] = (bl > NB) ? 64'(mag[i] >> (bl - NB)) : 64'(mag[i] << (NB - bl));
        sum = sum + sm[i] * sm[i];
      end
      norm = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((sm[i] << FRAC) + norm / 2) / norm;
        res[i] = (dir[i][127] != det[127]) ? TW'(-q) : TW'(q);
      end
      t = '{tx: res[0], ty: res[1], tz: res[2], degen: 1'b0};
    end
    tangent_q = {tangent_q, t};
  endtask

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 0, gap_left = 0;
  corner_t nxt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        take_corner('{x: pos_x_i, y: pos_y_i, z: pos_z_i, u: tex_u_i, v: tex_v_i});
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (corner_q.size() > 0) begin
          nxt = corner_q.pop_front();
          pos_x_i <= nxt.x; pos_y_i <= nxt.y; pos_z_i <= nxt.z;
          tex_u_i <= nxt.u; tex_v_i <= nxt.v;
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternate full-rate and random-stall phases, plus one long hold-off
  // so the result register stays full and the input side backs up.
  int rx_cycle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_cycle    <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= 3000 && rx_cycle < 7000)
        out_ready_i <= 1'b0;
      else if ((rx_cycle / 700) % 2 == 0)
        out_ready_i <= 1'b1;
      else
        out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  tangent_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tangent_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d degenerate=%0b", $time,
                 tangent_x_o, tangent_y_o, tangent_z_o, degenerate_o);
        failed = 1'b1;
      end else begin
        want = tangent_q.pop_front();
        if (tangent_x_o !== want.tx || tangent_y_o !== want.ty ||
            tangent_z_o !== want.tz || degenerate_o !== want.degen) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d degenerate=%0b", $time,
                   $signed(want.tx), $signed(want.ty), $signed(want.tz), want.degen);
          $display("%0t:          actual   x=%0d y=%0d z=%0d degenerate=%0b", $time,
                   tangent_x_o, tangent_y_o, tangent_z_o, degenerate_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Full-range values most often, some small ones near a unit scale, some extremes.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      7:          return 32'($signed($urandom_range(0, 64)) - 32);
      8:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic corner_t rand_corner();
    return '{x: pick_coord(), y: pick_coord(), z: pick_coord(),
             u: pick_coord(), v: pick_coord()};
  endfunction

  task automatic add_tri(corner_t a, corner_t b, corner_t c);
    corner_q = {corner_q, a};
    corner_q = {corner_q, b};
    corner_q = {corner_q, c};
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [31:0] MINC = 32'h8000_0000;

  initial begin
    corner_t a, b, c;
    // Directed: all zero, a plain unit triangle, its mirrored UV (negative det),
    // zero-area UV, coincident positions, and full-scale extremes.
    add_tri('{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0});
    add_tri('{0, 0, 0, 0, 0}, '{ONE, 0, 0, ONE, 0}, '{0, ONE, 0, 0, ONE});
    add_tri('{0, 0, 0, 0, 0}, '{ONE, 0, 0, 0, ONE}, '{0, ONE, 0, ONE, 0});
    add_tri('{0, 0, 0, 0, 0}, '{ONE, ONE, 0, ONE, ONE}, '{0, ONE, ONE, 2*ONE, 2*ONE});
    add_tri('{ONE, ONE, ONE, 0, 0}, '{ONE, ONE, ONE, ONE, 0}, '{ONE, ONE, ONE, 0, ONE});
    add_tri('{MINC, MINC, MINC, MINC, MINC}, '{MAXC, MAXC, MAXC, MAXC, MINC},
            '{MINC, MAXC, MINC, MINC, MAXC});
    add_tri('{MAXC, MINC, MAXC, MAXC, MAXC}, '{MINC, MAXC, MINC, MINC, MAXC},
            '{MAXC, MAXC, MINC, MAXC, MINC});
    add_tri('{0, 0, 0, 0, 0}, '{0, 0, 32'd1, 32'd1, 0}, '{0, 0, 0, 0, 32'd1});
    for (int t = 0; t < 266; t++) begin
      a = rand_corner(); b = rand_corner(); c = rand_corner();
      case ($urandom_range(0, 9))
        7: begin c.u = a.u; c.v = a.v; end
        8: begin b.x = a.x; b.y = a.y; b.z = a.z; c.x = a.x; c.y = a.y; c.z = a.z; end
        default: ;
      endcase
      add_tri(a, b, c);
    end
    fill_done = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (fill_done);
    while (corner_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (tangent_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
